>>> rtl/core/hsv_color_blob_centroid_macros.svh
// Assertion macros shared by the colour blob centroid RTL.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef HSV_COLOR_BLOB_CENTROID_MACROS_SVH
`define HSV_COLOR_BLOB_CENTROID_MACROS_SVH

// same-cycle implication
`define HCBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hcbc_pkg.sv
// Shared types and constants of the colour blob centroid block.
// No dependencies.
package hcbc_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 11;
    localparam int PIX_W     = 16;
    localparam int COORD_W   = 11;
    localparam int COUNT_W   = 21;
    localparam int OUT_W     = 48;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int PIX_DIV_STEPS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 4'd7;

    localparam logic [7:0] HUE_SECTOR = 8'd43;
    localparam logic [7:0] HUE_G_BASE = 8'd85;
    localparam logic [7:0] HUE_B_BASE = 8'd171;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat_low;
        logic [7:0] sat_high;
        logic [7:0] val_low;
        logic [7:0] val_high;
    } t_thr;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_SAT, S_HUE, S_CHECK, S_FEND, S_CX, S_CY, S_OUT
    } t_state;

endpackage

>>> rtl/core/hsv_color_blob_centroid.sv
// Top level of the HSV colour blob centroid block: configuration registers and wiring.
// Depends on hcbc_pkg, hcbc_front and hcbc_back.
//
//   channel   dir  handshake                 payload
//   s_*       in   s_tvalid / s_tready       s_tdata: pixel RGB565
//   m_*       out  m_tvalid / m_tready       m_tdata: mean column, mean row, match count
//                                            m_tuser: detected
//   cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A grey pixel skips the divider in the back end; any other takes two 16-step divides
// on the shared serial divider, for saturation and hue. The last pixel of a frame adds
// two full-width divides for the centroid, one per coordinate, unless no pixel matched.
// A four-entry queue lets the front keep taking pixels while the back end works.
// Reset is synchronous; a held result stalls the back end only at the next frame end.
module hsv_color_blob_centroid #(
    parameter int MAX_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,   // [10:0] mean column, [21:11] mean row,
                                                       // [42:22] match count, rest zero
    output logic                            m_tuser,   // [0] detected
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hcbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hcbc_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import hcbc_pkg::*;

    localparam int CW = $clog2(MAX_DIM);

    t_thr                  r_thr;
    logic [CFG_DAT_W-1:0]  r_fw, r_fh;
    logic                  q_valid, q_pop, q_fe;
    logic [PIX_W-1:0]      q_pixel;
    logic [CW-1:0]         q_col, q_row;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.hue_low  <= 8'd0;
            r_thr.hue_high <= 8'd20;
            r_thr.sat_low  <= 8'd100;
            r_thr.sat_high <= 8'd255;
            r_thr.val_low  <= 8'd100;
            r_thr.val_high <= 8'd255;
            r_fw           <= 11'd320;
            r_fh           <= 11'd240;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HUE_LOW:  r_thr.hue_low  <= i_cfg_data[7:0];
                REG_HUE_HIGH: r_thr.hue_high <= i_cfg_data[7:0];
                REG_SAT_LOW:  r_thr.sat_low  <= i_cfg_data[7:0];
                REG_SAT_HIGH: r_thr.sat_high <= i_cfg_data[7:0];
                REG_VAL_LOW:  r_thr.val_low  <= i_cfg_data[7:0];
                REG_VAL_HIGH: r_thr.val_high <= i_cfg_data[7:0];
                REG_WIDTH:    r_fw           <= i_cfg_data;
                REG_HEIGHT:   r_fh           <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    hcbc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_pixel   (s_tdata),
        .i_fw      (r_fw),
        .i_fh      (r_fh),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_pixel   (q_pixel),
        .o_col     (q_col),
        .o_row     (q_row),
        .o_fe      (q_fe)
    );

    hcbc_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_thr     (r_thr),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_pixel   (q_pixel),
        .i_col     (q_col),
        .i_row     (q_row),
        .i_fe      (q_fe),
        .o_tvalid  (m_tvalid),
        .i_tready  (m_tready),
        .o_tdata   (m_tdata),
        .o_tuser   (m_tuser)
    );

endmodule

>>> rtl/core/hcbc_front.sv
// Front end: accepts pixels, tracks raster position, queues work for the back end.
// Depends on hcbc_pkg.
module hcbc_front #(
    parameter int MAX_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [hcbc_pkg::PIX_W-1:0]      i_pixel,
    input  logic [hcbc_pkg::CFG_DAT_W-1:0]  i_fw,
    input  logic [hcbc_pkg::CFG_DAT_W-1:0]  i_fh,
    output logic                            o_q_valid,
    input  logic                            i_q_pop,
    output logic [hcbc_pkg::PIX_W-1:0]      o_pixel,
    output logic [$clog2(MAX_DIM)-1:0]      o_col,
    output logic [$clog2(MAX_DIM)-1:0]      o_row,
    output logic                            o_fe
);
    import hcbc_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int WW = CW + 1;

    logic [PIX_W-1:0] r_q_pix [Q_DEPTH];
    logic [CW-1:0]    r_q_col [Q_DEPTH];
    logic [CW-1:0]    r_q_row [Q_DEPTH];
    logic             r_q_fe  [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_AW:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_col, r_row;
    logic [WW-1:0]    w_lim, h_lim;
    logic             row_end, frame_end, push;

    always_comb begin
        if (i_fw == '0) begin
            w_lim = WW'(1);
        end else if (32'(i_fw) > MAX_DIM) begin
            w_lim = WW'(MAX_DIM);
        end else begin
            w_lim = WW'(i_fw);
        end
        if (i_fh == '0) begin
            h_lim = WW'(1);
        end else if (32'(i_fh) > MAX_DIM) begin
            h_lim = WW'(MAX_DIM);
        end else begin
            h_lim = WW'(i_fh);
        end
    end

    assign o_ready   = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign push      = i_valid && o_ready;
    assign row_end   = (WW'(r_col) + WW'(1)) >= w_lim;
    assign frame_end = row_end && ((WW'(r_row) + WW'(1)) >= h_lim);
    assign o_q_valid = (r_cnt != '0);
    assign o_pixel   = r_q_pix[r_rd];
    assign o_col     = r_q_col[r_rd];
    assign o_row     = r_q_row[r_rd];
    assign o_fe      = r_q_fe[r_rd];
    assign n_cnt     = r_cnt + (Q_AW+1)'(push) - (Q_AW+1)'(i_q_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_q_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (push) begin
                r_wr <= r_wr + Q_AW'(1);
                if (!row_end) begin
                    r_col <= r_col + CW'(1);
                end else begin
                    r_col <= '0;
                    r_row <= frame_end ? '0 : r_row + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_pix[r_wr] <= i_pixel;
            r_q_col[r_wr] <= r_col;
            r_q_row[r_wr] <= r_row;
            r_q_fe[r_wr]  <= frame_end;
        end
    end

endmodule

>>> rtl/core/hcbc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing; dividend is left-aligned by the caller.
module hcbc_div #(
    parameter int DW = 30,
    parameter int NW = 21
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DW-1:0]          i_dvd,
    input  logic [NW-1:0]          i_dsr,
    input  logic [$clog2(DW+1)-1:0] i_steps,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [DW-1:0]          o_quo
);
    localparam int SW = $clog2(DW+1);

    logic            r_busy, r_done;
    logic [SW-1:0]   r_cnt;
    logic [NW-1:0]   r_rem, r_dsr;
    logic [DW-1:0]   r_quo;
    logic [NW:0]     rem_sh;
    logic            ge;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_dsr;
            r_quo <= i_dvd;
        end else if (r_busy) begin
            r_rem <= ge ? NW'(rem_sh - {1'b0, r_dsr}) : rem_sh[NW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

endmodule

>>> rtl/core/hcbc_back.sv
// Back end: HSV conversion and window test, accumulation, centroid and result register.
// Depends on hcbc_pkg, hcbc_div and the assertion macro header.
`include "hsv_color_blob_centroid_macros.svh"
module hcbc_back #(
    parameter int MAX_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hcbc_pkg::t_thr                  i_thr,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  logic [hcbc_pkg::PIX_W-1:0]      i_pixel,
    input  logic [$clog2(MAX_DIM)-1:0]      i_col,
    input  logic [$clog2(MAX_DIM)-1:0]      i_row,
    input  logic                            i_fe,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [hcbc_pkg::OUT_W-1:0]      o_tdata,
    output logic                            o_tuser
);
    import hcbc_pkg::*;

    localparam int CW   = $clog2(MAX_DIM);
    localparam int SUMW = 3 * CW;
    localparam int CNTW = 2 * CW + 1;
    localparam int DW   = (SUMW > PIX_DIV_STEPS) ? SUMW : PIX_DIV_STEPS;
    localparam int NW   = CNTW;
    localparam int SW   = $clog2(DW + 1);

    t_state              r_state, n_state;
    logic [PIX_W-1:0]    r_pix;
    logic [CW-1:0]       r_col, r_row;
    logic                r_fe;
    logic [7:0]          r_s, r_h;
    logic [SUMW-1:0]     r_sx, r_sy;
    logic [CNTW-1:0]     r_cnt;
    logic [COORD_W-1:0]  r_cx, r_cy;
    logic                r_mvalid;
    logic [OUT_W-1:0]    r_tdata;
    logic                r_tuser;

    logic [7:0]  cr, cg, cb, mx, mn, delta, ha, hb, diff, hbase;
    logic        rmax, gmax, hneg, match, hue_ok;
    logic [15:0] sat_num, hue_num;
    logic        div_start, div_busy, div_done;
    logic [DW-1:0]   div_dvd, div_quo;
    logic [NW-1:0]   div_dsr;
    logic [SW-1:0]   div_steps;

    assign cr = {r_pix[15:11], 3'b000};
    assign cg = {r_pix[10:5], 2'b00};
    assign cb = {r_pix[4:0], 3'b000};

    always_comb begin
        mx = (cr > cg) ? ((cr > cb) ? cr : cb) : ((cg > cb) ? cg : cb);
        mn = (cr < cg) ? ((cr < cb) ? cr : cb) : ((cg < cb) ? cg : cb);
        delta = mx - mn;
        rmax = (cr == mx);
        gmax = (cg == mx);
        if (rmax) begin
            ha = cg; hb = cb; hbase = 8'd0;
        end else if (gmax) begin
            ha = cb; hb = cr; hbase = HUE_G_BASE;
        end else begin
            ha = cr; hb = cg; hbase = HUE_B_BASE;
        end
        hneg = (ha < hb);
        diff = hneg ? (hb - ha) : (ha - hb);
        if (rmax && hneg) begin
            hbase = FULL_SCALE;
        end
        sat_num = {delta, 8'h00} - 16'(delta);
        hue_num = 16'(diff) * 16'(HUE_SECTOR);
    end

    always_comb begin
        if (i_thr.hue_low <= i_thr.hue_high) begin
            hue_ok = (r_h >= i_thr.hue_low) && (r_h <= i_thr.hue_high);
        end else begin
            hue_ok = (r_h >= i_thr.hue_low) || (r_h <= i_thr.hue_high);
        end
        match = hue_ok && (r_s >= i_thr.sat_low) && (r_s <= i_thr.sat_high)
                && (mx >= i_thr.val_low) && (mx <= i_thr.val_high);
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_dvd   = DW'(sat_num) << (DW - PIX_DIV_STEPS);
        div_dsr   = NW'(mx);
        div_steps = SW'(PIX_DIV_STEPS);
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (delta == '0) begin
                    n_state = S_CHECK;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_SAT;
                end
            end
            S_SAT: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_dvd   = DW'(hue_num) << (DW - PIX_DIV_STEPS);
                    div_dsr   = NW'(delta);
                    n_state   = S_HUE;
                end
            end
            S_HUE: begin
                if (div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = r_fe ? S_FEND : S_IDLE;
            end
            S_FEND: begin
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DW'(r_sx);
                    div_dsr   = r_cnt;
                    div_steps = SW'(DW);
                    n_state   = S_CX;
                end
            end
            S_CX: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_dvd   = DW'(r_sy);
                    div_dsr   = r_cnt;
                    div_steps = SW'(DW);
                    n_state   = S_CY;
                end
            end
            S_CY: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_mvalid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sx     <= '0;
            r_sy     <= '0;
            r_cnt    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_mvalid && i_tready) begin
                r_mvalid <= 1'b0;
            end
            if (r_state == S_CHECK && match) begin
                r_sx  <= r_sx + SUMW'(r_col);
                r_sy  <= r_sy + SUMW'(r_row);
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (r_state == S_OUT && !r_mvalid) begin
                r_mvalid <= 1'b1;
                r_sx     <= '0;
                r_sy     <= '0;
                r_cnt    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pix <= i_pixel;
            r_col <= i_col;
            r_row <= i_row;
            r_fe  <= i_fe;
        end
        if (r_state == S_PREP) begin
            r_s <= '0;
            r_h <= '0;
        end
        if (r_state == S_SAT && div_done) begin
            r_s <= div_quo[7:0];
        end
        if (r_state == S_HUE && div_done) begin
            r_h <= hneg ? (hbase - div_quo[7:0]) : (hbase + div_quo[7:0]);
        end
        if (r_state == S_FEND && r_cnt == '0) begin
            r_cx <= '1;
            r_cy <= '1;
        end
        if (r_state == S_CX && div_done) begin
            r_cx <= div_quo[COORD_W-1:0];
        end
        if (r_state == S_CY && div_done) begin
            r_cy <= div_quo[COORD_W-1:0];
        end
        if (r_state == S_OUT && !r_mvalid) begin
            r_tdata <= {5'b0, COUNT_W'(r_cnt), r_cy, r_cx};
            r_tuser <= (r_cnt != '0);
        end
    end

    hcbc_div #(
        .DW (DW),
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dsr   (div_dsr),
        .i_steps (div_steps),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_tvalid = r_mvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;

    `HCBC_ASSERT_NOW(a_idle_div, r_state == S_IDLE || r_state == S_CHECK, !div_busy, "divider busy")
    `HCBC_ASSERT_NEXT(a_load_out, r_state == S_OUT && !r_mvalid, r_mvalid && r_state == S_IDLE, "no load")
    `HCBC_ASSERT_NOW(a_det_cnt, r_mvalid, r_tuser == (r_tdata[42:22] != '0), "flag vs count")

endmodule

>>> dv/hsv_color_blob_centroid_tb.sv
// Self-checking testbench for hsv_color_blob_centroid: streams RGB565 frames of small and
// saturated geometry under random windows and stalls, predicts each frame's centroid result.
// Depends on hcbc_pkg and the hsv_color_blob_centroid RTL.
module hsv_color_blob_centroid_tb;
    import hcbc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_ABSENT = 4'd9;

    typedef struct {
        logic [10:0] cx;
        logic [10:0] cy;
        logic [20:0] cnt;
        logic        det;
    } t_blob;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    logic [15:0] pixel_q[$];
    t_blob       blob_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    int          frames_seen = 0;
    int          pixels_sent = 0;

    // predictor copy of registers and state
    int     hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi, wid_reg, hgt_reg;
    int     col_pos, row_pos, match_cnt;
    longint sum_col, sum_row;

    hsv_color_blob_centroid dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic bit pixel_in_window(logic [15:0] px);
        int r, g, b, mx, mn, d, h, s;
        r = px[15:11] << 3;
        g = px[10:5] << 2;
        b = px[4:0] << 3;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        d = mx - mn;
        if (d == 0) begin
            h = 0;
            s = 0;
        end else begin
            s = d * 255 / mx;
            if (r == mx)
                h = (g >= b) ? 43 * (g - b) / d : 255 - 43 * (b - g) / d;
            else if (g == mx)
                h = (b >= r) ? 85 + 43 * (b - r) / d : 85 - 43 * (r - b) / d;
            else
                h = (r >= g) ? 171 + 43 * (r - g) / d : 171 - 43 * (g - r) / d;
            h = h & 255;
        end
        if (s < sat_lo || s > sat_hi || mx < val_lo || mx > val_hi) return 1'b0;
        if (hue_lo <= hue_hi) return h >= hue_lo && h <= hue_hi;
        return h >= hue_lo || h <= hue_hi;
    endfunction

    function automatic int clamp_dim(int dv);
        if (dv == 0) return 1;
        if (dv > 1024) return 1024;
        return dv;
    endfunction

    task automatic accumulate_pixel(logic [15:0] px);
        t_blob e;
        bit    row_end;
        if (pixel_in_window(px)) begin
            sum_col += col_pos;
            sum_row += row_pos;
            match_cnt++;
        end
        row_end = col_pos + 1 >= clamp_dim(wid_reg);
        if (!row_end) begin
            col_pos++;
        end else begin
            col_pos = 0;
            if (row_pos + 1 < clamp_dim(hgt_reg)) begin
                row_pos++;
            end else begin
                row_pos = 0;
                if (match_cnt > 0) begin
                    e.cx = 11'(sum_col / match_cnt);
                    e.cy = 11'(sum_row / match_cnt);
                    e.cnt = 21'(match_cnt);
                    e.det = 1'b1;
                end else begin
                    e.cx = 11'h7FF;
                    e.cy = 11'h7FF;
                    e.cnt = '0;
                    e.det = 1'b0;
                end
                blob_q.push_back(e);
                sum_col = 0;
                sum_row = 0;
                match_cnt = 0;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pixel_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk)
        m_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);

    // monitor
    always @(posedge i_clk) begin
        t_blob e;
        if (i_rst_n && s_tvalid && s_tready) begin
            accumulate_pixel(s_tdata);
            pixels_sent++;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            frames_seen++;
            if (blob_q.size() == 0) begin
                $display("%0t: unexpected result, actual cx=%0d cy=%0d cnt=%0d det=%0b",
                         $time, m_tdata[10:0], m_tdata[21:11], m_tdata[42:22], m_tuser);
                errors++;
            end else begin
                e = blob_q.pop_front();
                if (m_tdata[10:0] !== e.cx || m_tdata[21:11] !== e.cy ||
                    m_tdata[42:22] !== e.cnt || m_tuser !== e.det) begin
                    $display("%0t: mismatch, expected cx=%0d cy=%0d cnt=%0d det=%0b",
                             $time, e.cx, e.cy, e.cnt, e.det);
                    $display("%0t:           actual   cx=%0d cy=%0d cnt=%0d det=%0b",
                             $time, m_tdata[10:0], m_tdata[21:11], m_tdata[42:22],
                             m_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_HUE_LOW:  hue_lo = val[7:0];
            REG_HUE_HIGH: hue_hi = val[7:0];
            REG_SAT_LOW:  sat_lo = val[7:0];
            REG_SAT_HIGH: sat_hi = val[7:0];
            REG_VAL_LOW:  val_lo = val[7:0];
            REG_VAL_HIGH: val_hi = val[7:0];
            REG_WIDTH:    wid_reg = val;
            REG_HEIGHT:   hgt_reg = val;
            default: ;
        endcase
    endtask

    // hold until every request is taken and every result is back, then let the back end drain
    task automatic drain();
        while (pixel_q.size() > 0 || s_tvalid || blob_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_windows(int hl, int hh, int sl, int sh, int vl, int vh);
        write_reg(REG_HUE_LOW, 11'(hl));
        write_reg(REG_HUE_HIGH, 11'(hh));
        write_reg(REG_SAT_LOW, 11'(sl));
        write_reg(REG_SAT_HIGH, 11'(sh));
        write_reg(REG_VAL_LOW, 11'(vl));
        write_reg(REG_VAL_HIGH, 11'(vh));
    endtask

    function automatic logic [15:0] random_pixel();
        logic [15:0] base[8] = '{16'hF800, 16'h07E0, 16'h001F, 16'hFFE0,
                                 16'h07FF, 16'hF81F, 16'hF801, 16'h8410};
        if ($urandom_range(1)) return 16'($urandom);
        return base[$urandom_range(7)] ^ 16'($urandom_range(3) << ($urandom_range(3) * 5));
    endfunction

    initial begin
        logic [15:0] directed[14];
        int n;
        directed = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
                     16'hFFE0, 16'h07FF, 16'hF81F, 16'hF801, 16'h8410,
                     16'h0001, 16'h0020, 16'h0800, 16'hF81E};
        hue_lo = 0; hue_hi = 20; sat_lo = 100; sat_hi = 255; val_lo = 100; val_hi = 255;
        wid_reg = 320; hgt_reg = 240;
        col_pos = 0; row_pos = 0; match_cnt = 0; sum_col = 0; sum_row = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one pixel per frame: width zero, height one
        write_reg(REG_WIDTH, 11'd0);
        write_reg(REG_HEIGHT, 11'd1);
        write_reg(REG_ABSENT, 11'h7FF);
        set_windows(0, 255, 0, 255, 0, 255);
        foreach (directed[i]) pixel_q.push_back(directed[i]);
        drain();
        set_windows(240, 20, 100, 255, 100, 255);
        foreach (directed[i]) pixel_q.push_back(directed[i]);
        drain();

        // random phases with small geometry
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (ph % 3 == 0)
                set_windows($urandom_range(255), $urandom_range(255), 0, 255, 0, 255);
            else
                set_windows($urandom_range(255), $urandom_range(255), $urandom_range(150),
                            $urandom_range(100, 255), $urandom_range(150),
                            $urandom_range(100, 255));
            write_reg(REG_WIDTH, 11'($urandom_range(8)));
            write_reg(REG_HEIGHT, 11'($urandom_range(6)));
            n = $urandom_range(25, 45);
            repeat (n) pixel_q.push_back(random_pixel());
            drain();
        end

        // widest row: width saturates, the open frame is closed by a width of one
        send_idle_pct = 0;
        recv_stall_pct = 30;
        set_windows(0, 255, 0, 255, 0, 255);
        write_reg(REG_WIDTH, 11'h7FF);
        write_reg(REG_HEIGHT, 11'd1);
        repeat (250) pixel_q.push_back(($urandom_range(7) == 0) ? random_pixel() : 16'h0000);
        drain();
        write_reg(REG_WIDTH, 11'd1);
        pixel_q.push_back(16'hF800);
        drain();

        // tallest column: height saturates, the open frame is closed by a height of one
        write_reg(REG_HEIGHT, 11'h7FF);
        repeat (100) pixel_q.push_back(($urandom_range(7) == 0) ? random_pixel() : 16'h8410);
        drain();
        write_reg(REG_HEIGHT, 11'd1);
        pixel_q.push_back(16'h07E0);
        drain();

        $display("Covered %0d pixels and %0d frame results across directed, random",
                 pixels_sent, frames_seen);
        $display("and saturated geometry phases with sender and receiver stalls.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
